FILE: sv/first_fit_run_allocator_assert.svh
// Assertion macros used by the checker file of the first-fit run allocator.
`ifndef FIRST_FIT_RUN_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_RUN_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFRA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ffra: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FFRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ffra: assertion failed");

`endif

FILE: sv/ffra_pkg.sv
// Package of the first-fit run allocator: sizes, codes, beat types and helpers.
package ffra_pkg;

  localparam int unsigned POOL_SIZE = 65536;
  localparam int unsigned MAX_SLICE = 1024;
  localparam int unsigned MAX_RUNS  = 64;

  localparam int unsigned START_W = 16;
  localparam int unsigned LEN_W   = 17;
  localparam int unsigned ENTRY_W = START_W + LEN_W;
  localparam int unsigned IDX_W   = $clog2(MAX_RUNS);
  localparam int unsigned CNT_W   = $clog2(MAX_RUNS + 1);

  localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};
  localparam logic [LEN_W-1:0] POOL_LEN  = LEN_W'(POOL_SIZE);
  localparam logic [LEN_W-1:0] SLICE_LIM = LEN_W'(MAX_SLICE);
  localparam logic [CNT_W-1:0] RUNS_LIM  = CNT_W'(MAX_RUNS);

  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_POOL_READY = 1'b0;

  typedef enum logic {
    CMD_ACQUIRE,
    CMD_RELEASE
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FAIL,
    ST_FULL,
    ST_EMPTY
  } status_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [LEN_W-1:0]   slice_count;
    logic [START_W-1:0] slice_offset;
  } ffra_in_t;

  typedef struct packed {
    status_e            status;
    logic [START_W-1:0] granted_offset;
    logic [LEN_W-1:0]   granted_count;
    logic [LEN_W-1:0]   high_water;
  } ffra_out_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
  } run_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W+1:0] v);
    return (v > (LEN_W+2)'(LEN_MAX)) ? LEN_MAX : v[LEN_W-1:0];
  endfunction

endpackage

FILE: sv/first_fit_run_allocator.sv
// Top level of the first-fit run allocator: sequencer around the free-run table RAM.
//
//   channel  direction  handshake                 beat
//   in       in         in_valid_i / in_ready_o   ffra_in_t command
//   out      out        out_valid_o / out_ready_i ffra_out_t result
//   cfg      in         APB psel/penable/pready   pool_ready register
//
// One command is worked on at a time; the free-run table is scanned one entry per
// cycle through the single RAM read port, and removals or insertions move one entry
// per cycle. After reset the table holds the single full-pool run with no clearing
// pass. A result waiting on the output does not block the next command until it
// finishes.
module first_fit_run_allocator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ffra_pkg::ffra_in_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output ffra_pkg::ffra_out_t              out_data_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ffra_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import ffra_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_AUPD = 3'd2;
  localparam logic [2:0] S_RDEC = 3'd3;
  localparam logic [2:0] S_DROP = 3'd4;
  localparam logic [2:0] S_INS  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   total_q, total_d;
  logic [LEN_W-1:0]   high_q, high_d;
  logic               init_q, init_d;
  logic               pool_ready_q, pool_ready_d;
  logic               out_valid_q, out_valid_d;
  logic               rdv_q, rdv_d;
  logic [CNT_W-1:0]   idx_q, idx_d;

  cmd_e               cmd_q, cmd_d;
  logic [LEN_W-1:0]   cnt_q, cnt_d;
  logic [START_W-1:0] off_q, off_d;
  logic [LEN_W-1:0]   want_q, want_d;
  logic [IDX_W-1:0]   rda_q, rda_d;
  logic               rdi_q, rdi_d;
  run_t               prev_q, prev_d;
  logic               prev_ok_q, prev_ok_d;
  run_t               nxt_q, nxt_d;
  logic               nxt_ok_q, nxt_ok_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  status_e            stat_q, stat_d;
  logic [START_W-1:0] goff_q, goff_d;
  logic [LEN_W-1:0]   gcnt_q, gcnt_d;
  ffra_out_t          out_q, out_d;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  run_t               wr_data;
  logic [ENTRY_W-1:0] ram_rdata;
  run_t               rdata;

  logic [LEN_W-1:0]   hm_sum;
  logic [LEN_W:0]     jn_sum;
  logic [LEN_W:0]     jp_sum;
  logic [LEN_W+1:0]   both_sum;
  logic [LEN_W+1:0]   prev_sum;
  logic [LEN_W+1:0]   next_sum;
  logic               join_prev;
  logic               join_next;
  logic [CNT_W-1:0]   pos_m1;
  logic [CNT_W-1:0]   idx_p1;
  logic [CNT_W-1:0]   idx_m1;
  logic               scan_go;
  logic               drop_go;
  logic               ins_go;
  logic               cfg_wr;
  logic [LEN_W-1:0]   in_want;

  ffra_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_RUNS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (ram_rdata)
  );

  // Entry zero reads as the full-pool run until it is first written.
  assign rdata = rdi_q ? run_t'({{START_W{1'b0}}, POOL_LEN}) : run_t'(ram_rdata);

  assign hm_sum    = LEN_W'(nxt_q.start) + want_q;
  assign jn_sum    = (LEN_W+1)'(off_q) + (LEN_W+1)'(cnt_q);
  assign jp_sum    = (LEN_W+1)'(prev_q.start) + (LEN_W+1)'(prev_q.length);
  assign both_sum  = (LEN_W+2)'(prev_q.length) + (LEN_W+2)'(cnt_q) + (LEN_W+2)'(nxt_q.length);
  assign prev_sum  = (LEN_W+2)'(prev_q.length) + (LEN_W+2)'(cnt_q);
  assign next_sum  = (LEN_W+2)'(nxt_q.length) + (LEN_W+2)'(cnt_q);
  assign join_next = nxt_ok_q && (jn_sum == (LEN_W+1)'(nxt_q.start));
  assign join_prev = prev_ok_q && (jp_sum == (LEN_W+1)'(off_q));
  assign pos_m1    = pos_q - CNT_W'(1);
  assign idx_p1    = idx_q + CNT_W'(1);
  assign idx_m1    = idx_q - CNT_W'(1);
  assign scan_go   = idx_q < total_q;
  assign drop_go   = idx_p1 < total_q;
  assign ins_go    = idx_q > pos_q;
  assign in_want   = (in_data_i.slice_count < SLICE_LIM) ? in_data_i.slice_count : SLICE_LIM;

  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1 -: REG_IDX_W] == REG_POOL_READY);

  assign pready      = 1'b1;
  assign prdata      = (paddr[ADDR_W-1 -: REG_IDX_W] == REG_POOL_READY) ?
                       {31'b0, pool_ready_q} : 32'b0;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d      = state_q;
    total_d      = total_q;
    high_d       = high_q;
    init_d       = init_q;
    pool_ready_d = pool_ready_q;
    out_valid_d  = out_valid_q;
    idx_d        = idx_q;
    cmd_d        = cmd_q;
    cnt_d        = cnt_q;
    off_d        = off_q;
    want_d       = want_q;
    prev_d       = prev_q;
    prev_ok_d    = prev_ok_q;
    nxt_d        = nxt_q;
    nxt_ok_d     = nxt_ok_q;
    pos_d        = pos_q;
    stat_d       = stat_q;
    goff_d       = goff_q;
    gcnt_d       = gcnt_q;
    out_d        = out_q;
    rd_en        = 1'b0;
    rd_addr      = idx_q[IDX_W-1:0];
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;

    if (cfg_wr) begin
      pool_ready_d = pwdata[0];
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = in_data_i.cmd;
          cnt_d     = in_data_i.slice_count;
          off_d     = in_data_i.slice_offset;
          want_d    = in_want;
          idx_d     = '0;
          prev_ok_d = 1'b0;
          nxt_ok_d  = 1'b0;
          stat_d    = ST_OK;
          goff_d    = '0;
          gcnt_d    = '0;
          state_d   = S_SCAN;
          if (in_data_i.cmd == CMD_ACQUIRE) begin
            if (!pool_ready_q || (in_data_i.slice_count == '0)) begin
              stat_d  = ST_FAIL;
              state_d = S_DONE;
            end
          end else if (in_data_i.slice_count == '0) begin
            stat_d  = ST_EMPTY;
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (scan_go) begin
          rd_en = 1'b1;
          idx_d = idx_p1;
        end
        if (cmd_q == CMD_ACQUIRE) begin
          if (rdv_q && (rdata.length >= want_q)) begin
            nxt_d   = rdata;
            pos_d   = CNT_W'(rda_q);
            state_d = S_AUPD;
          end else if (!scan_go && !rdv_q) begin
            stat_d  = ST_FAIL;
            state_d = S_DONE;
          end
        end else begin
          if (rdv_q && (rdata.start >= off_q)) begin
            nxt_d    = rdata;
            nxt_ok_d = 1'b1;
            pos_d    = CNT_W'(rda_q);
            state_d  = S_RDEC;
          end else begin
            if (rdv_q) begin
              prev_d    = rdata;
              prev_ok_d = 1'b1;
            end
            if (!scan_go && !rdv_q) begin
              pos_d   = total_q;
              state_d = S_RDEC;
            end
          end
        end
      end
      S_AUPD: begin
        goff_d = nxt_q.start;
        gcnt_d = want_q;
        if (hm_sum > high_q) begin
          high_d = hm_sum;
        end
        if (nxt_q.length == want_q) begin
          idx_d   = pos_q;
          state_d = S_DROP;
        end else begin
          wr_en          = 1'b1;
          wr_addr        = pos_q[IDX_W-1:0];
          wr_data.start  = nxt_q.start + want_q[START_W-1:0];
          wr_data.length = nxt_q.length - want_q;
          state_d        = S_DONE;
        end
      end
      S_RDEC: begin
        if (join_prev && join_next) begin
          wr_en          = 1'b1;
          wr_addr        = pos_m1[IDX_W-1:0];
          wr_data.start  = prev_q.start;
          wr_data.length = sat_len(both_sum);
          idx_d          = pos_q;
          state_d        = S_DROP;
        end else if (join_prev) begin
          wr_en          = 1'b1;
          wr_addr        = pos_m1[IDX_W-1:0];
          wr_data.start  = prev_q.start;
          wr_data.length = sat_len(prev_sum);
          state_d        = S_DONE;
        end else if (join_next) begin
          wr_en          = 1'b1;
          wr_addr        = pos_q[IDX_W-1:0];
          wr_data.start  = off_q;
          wr_data.length = sat_len(next_sum);
          state_d        = S_DONE;
        end else if (total_q >= RUNS_LIM) begin
          stat_d  = ST_FULL;
          state_d = S_DONE;
        end else begin
          idx_d   = total_q;
          state_d = S_INS;
        end
      end
      S_DROP: begin
        if (drop_go) begin
          rd_en   = 1'b1;
          rd_addr = idx_p1[IDX_W-1:0];
          idx_d   = idx_p1;
        end
        if (rdv_q) begin
          wr_en   = 1'b1;
          wr_addr = rda_q - IDX_W'(1);
          wr_data = rdata;
        end
        if (!drop_go && !rdv_q) begin
          total_d = total_q - CNT_W'(1);
          state_d = S_DONE;
        end
      end
      S_INS: begin
        if (ins_go) begin
          rd_en   = 1'b1;
          rd_addr = idx_m1[IDX_W-1:0];
          idx_d   = idx_m1;
        end
        if (rdv_q) begin
          wr_en   = 1'b1;
          wr_addr = rda_q + IDX_W'(1);
          wr_data = rdata;
        end
        if (!ins_go && !rdv_q) begin
          wr_en          = 1'b1;
          wr_addr        = pos_q[IDX_W-1:0];
          wr_data.start  = off_q;
          wr_data.length = cnt_q;
          total_d        = total_q + CNT_W'(1);
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status         = stat_q;
          out_d.granted_offset = goff_q;
          out_d.granted_count  = gcnt_q;
          out_d.high_water     = high_q;
          out_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (wr_en && (wr_addr == '0)) begin
      init_d = 1'b0;
    end
  end

  assign rdv_d = rd_en;
  assign rda_d = rd_addr;
  assign rdi_d = init_q && (rd_addr == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      total_q      <= CNT_W'(1);
      high_q       <= '0;
      init_q       <= 1'b1;
      pool_ready_q <= 1'b1;
      out_valid_q  <= 1'b0;
      rdv_q        <= 1'b0;
      idx_q        <= '0;
    end else begin
      state_q      <= state_d;
      total_q      <= total_d;
      high_q       <= high_d;
      init_q       <= init_d;
      pool_ready_q <= pool_ready_d;
      out_valid_q  <= out_valid_d;
      rdv_q        <= rdv_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    cnt_q     <= cnt_d;
    off_q     <= off_d;
    want_q    <= want_d;
    rda_q     <= rda_d;
    rdi_q     <= rdi_d;
    prev_q    <= prev_d;
    prev_ok_q <= prev_ok_d;
    nxt_q     <= nxt_d;
    nxt_ok_q  <= nxt_ok_d;
    pos_q     <= pos_d;
    stat_q    <= stat_d;
    goff_q    <= goff_d;
    gcnt_q    <= gcnt_d;
    out_q     <= out_d;
  end

endmodule

FILE: sv/ffra_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ffra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/ffra_checker.sv
// Port-level assertion checker of the first-fit run allocator and its bind.
`include "first_fit_run_allocator_assert.svh"

module ffra_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input ffra_pkg::ffra_out_t         out_data_o
);
  import ffra_pkg::*;

  // A stalled result beat stays put.
  `FFRA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  // Commands are taken one at a time.
  `FFRA_ASSERT_NEXT(a_one_cmd, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `FFRA_ASSERT_NOW(a_fail_zero, clk_i, rst_ni, out_valid_o && (out_data_o.status != ST_OK), (out_data_o.granted_count == '0) && (out_data_o.granted_offset == '0))
  `FFRA_ASSERT_NOW(a_grant_ok, clk_i, rst_ni, out_valid_o && (out_data_o.granted_count != '0), (out_data_o.status == ST_OK) && (out_data_o.granted_count <= SLICE_LIM))
  // The high-water mark never falls between consecutive result beats.
  `FFRA_ASSERT_NOW(a_hw_mono, clk_i, rst_ni, out_valid_o && $past(out_valid_o), out_data_o.high_water >= $past(out_data_o.high_water))

endmodule

bind first_fit_run_allocator ffra_checker u_ffra_checker (.*);

FILE: tb/sv/ffra_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class that mirrors the free-run table and checks each result beat.
package ffra_tb_pkg;
  import ffra_pkg::*;

  class alloc_tracker;
    logic [START_W-1:0] run_start [MAX_RUNS];
    logic [LEN_W-1:0]   run_length[MAX_RUNS];
    int unsigned        run_total;
    logic [LEN_W-1:0]   high_mark;
    bit                 pool_ready;
    ffra_out_t          pending_results[$];
    int unsigned        errors;
    int unsigned        results_seen;

    function new();
      for (int i = 0; i < MAX_RUNS; i++) begin
        run_start[i]  = '0;
        run_length[i] = '0;
      end
      run_length[0] = POOL_LEN;
      run_total     = 1;
      high_mark     = '0;
      pool_ready    = 1'b1;
      errors        = 0;
      results_seen  = 0;
    endfunction

    function void set_pool_ready(input bit v);
      pool_ready = v;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function logic [LEN_W-1:0] clip_length(input longint unsigned v);
      return (v > longint'(LEN_MAX)) ? LEN_MAX : v[LEN_W-1:0];
    endfunction

    function void remove_run(input int unsigned idx);
      for (int unsigned k = idx; k + 1 < run_total; k++) begin
        run_start[k]  = run_start[k + 1];
        run_length[k] = run_length[k + 1];
      end
      run_total--;
    endfunction

    function ffra_out_t apply_command(input ffra_in_t c);
      ffra_out_t          r;
      logic [LEN_W-1:0]   cnt;
      logic [START_W-1:0] off;
      int unsigned        want;
      int unsigned        pos;
      int unsigned        slice_end;
      int unsigned        prev_end;
      bit                 join_prev;
      bit                 join_next;
      cnt              = c.slice_count;
      off              = c.slice_offset;
      r.status         = ST_OK;
      r.granted_offset = '0;
      r.granted_count  = '0;
      if (c.cmd == CMD_ACQUIRE) begin
        r.status = ST_FAIL;
        if (pool_ready && cnt != 0) begin
          want = (cnt < MAX_SLICE) ? int'(cnt) : MAX_SLICE;
          for (int unsigned i = 0; i < run_total; i++) begin
            if (run_length[i] >= want) begin
              r.granted_offset = run_start[i];
              r.granted_count  = want[LEN_W-1:0];
              if (run_length[i] == want) begin
                remove_run(i);
              end else begin
                run_start[i]  = run_start[i] + want[START_W-1:0];
                run_length[i] = run_length[i] - want[LEN_W-1:0];
              end
              slice_end = r.granted_offset + want;
              if (slice_end > high_mark) begin
                high_mark = slice_end[LEN_W-1:0];
              end
              r.status = ST_OK;
              break;
            end
          end
        end
      end else if (cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        pos = 0;
        while (pos < run_total && run_start[pos] < off) pos++;
        slice_end = off + cnt;
        join_next = 1'b0;
        join_prev = 1'b0;
        if (pos < run_total) begin
          join_next = (slice_end == run_start[pos]);
        end
        if (pos > 0) begin
          prev_end  = run_start[pos - 1] + run_length[pos - 1];
          join_prev = (prev_end == off);
        end
        if (join_prev && join_next) begin
          run_length[pos - 1] = clip_length(64'(run_length[pos - 1]) + 64'(cnt) +
                                            64'(run_length[pos]));
          remove_run(pos);
        end else if (join_prev) begin
          run_length[pos - 1] = clip_length(64'(run_length[pos - 1]) + 64'(cnt));
        end else if (join_next) begin
          run_start[pos]  = off;
          run_length[pos] = clip_length(64'(run_length[pos]) + 64'(cnt));
        end else if (run_total >= MAX_RUNS) begin
          r.status = ST_FULL;
        end else begin
          for (int unsigned i = run_total; i > pos; i--) begin
            run_start[i]  = run_start[i - 1];
            run_length[i] = run_length[i - 1];
          end
          run_start[pos]  = off;
          run_length[pos] = cnt;
          run_total++;
        end
      end
      r.high_water = high_mark;
      return r;
    endfunction

    function ffra_out_t note_command(input ffra_in_t c);
      ffra_out_t r;
      r = apply_command(c);
      pending_results.insert(pending_results.size(), r);
      return r;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 200) begin
        $display("MISMATCH: %s", msg);
      end
    endtask

    task check_result(input ffra_out_t got);
      ffra_out_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d arrived with no command outstanding", results_seen));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          report($sformatf("result %0d: status %0d, expected %0d",
                           results_seen, got.status, want.status));
        end
        if (got.granted_offset !== want.granted_offset) begin
          report($sformatf("result %0d: granted_offset %0d, expected %0d",
                           results_seen, got.granted_offset, want.granted_offset));
        end
        if (got.granted_count !== want.granted_count) begin
          report($sformatf("result %0d: granted_count %0d, expected %0d",
                           results_seen, got.granted_count, want.granted_count));
        end
        if (got.high_water !== want.high_water) begin
          report($sformatf("result %0d: high_water %0d, expected %0d",
                           results_seen, got.high_water, want.high_water));
        end
      end
    endtask
  endclass

endpackage

FILE: tb/sv/tb_first_fit_run_allocator.sv
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, APB writes, command and result beats.
module tb_first_fit_run_allocator;
  import ffra_pkg::*;
  import ffra_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1500000;
  localparam int unsigned DRAIN_CYCLES = 100;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  ffra_in_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  ffra_out_t          out_data_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [ADDR_W-1:0]  paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  alloc_tracker tracker = new();
  run_t         held[$];
  run_t         last_freed = '0;
  bit           calm = 1'b0;
  int unsigned  stall_left = 0;
  int unsigned  cycle_count = 0;

  first_fit_run_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) begin
      return 0;
    end else if (r < 97) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 6);
  endfunction

  function automatic ffra_in_t mk_cmd(input cmd_e cmd, input int unsigned cnt,
                                      input int unsigned off);
    ffra_in_t c;
    c.cmd          = cmd;
    c.slice_count  = cnt[LEN_W-1:0];
    c.slice_offset = off[START_W-1:0];
    return c;
  endfunction

  // Result beats are taken with random back-pressure, none while calm is set.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        tracker.check_result(out_data_o);
      end
      if (calm) begin
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left  <= pick_gap();
      end
    end
  end

  task automatic send_command(input ffra_in_t c, output ffra_out_t predicted);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = tracker.note_command(c);
  endtask

  task automatic acquire(input int unsigned cnt, input int unsigned off);
    ffra_out_t r;
    send_command(mk_cmd(CMD_ACQUIRE, cnt, off), r);
    if (r.status == ST_OK) begin
      held.insert(held.size(), run_t'{start: r.granted_offset, length: r.granted_count});
    end
  endtask

  task automatic release_slice(input int unsigned off, input int unsigned cnt);
    ffra_out_t r;
    send_command(mk_cmd(CMD_RELEASE, cnt, off), r);
    last_freed = '{start: off[START_W-1:0], length: cnt[LEN_W-1:0]};
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.outstanding() > 0);
  endtask

  task automatic write_pool_ready(input bit v);
    in_valid_i <= 1'b0;
    psel       <= 1'b1;
    penable    <= 1'b0;
    pwrite     <= 1'b1;
    paddr      <= ADDR_W'(4 * REG_POOL_READY);
    pwdata     <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_pool_ready(v);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[0] !== v) begin
      tracker.report($sformatf("pool_ready read back as %0d, expected %0d", prdata[0], v));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int unsigned random_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) begin
      return 0;
    end else if (r < 7) begin
      return POOL_SIZE;
    end else if (r < 15) begin
      return $urandom_range(POOL_SIZE, MAX_SLICE + 1);
    end else if (r < 55) begin
      return $urandom_range(16, 1);
    end
    return $urandom_range(MAX_SLICE, 1);
  endfunction

  // Mostly well-formed acquire and release traffic, with a little noise.
  task automatic run_mix(input int unsigned n);
    int unsigned pick;
    int unsigned idx;
    run_t        s;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 1) begin
        wait_drained();
      end
      if (pick < 46) begin
        acquire(random_count(), $urandom_range(65535));
      end else if (pick < 92 && held.size() > 0) begin
        idx = $urandom_range(held.size() - 1);
        s   = held[idx];
        held.delete(idx);
        release_slice(s.start, s.length);
      end else begin
        case ($urandom_range(2))
          0: begin
            release_slice($urandom_range(65535), 0);
          end
          1: begin
            release_slice(last_freed.start, last_freed.length);
          end
          default: begin
            if ($urandom_range(7) == 0) begin
              release_slice($urandom_range(65535), $urandom_range(POOL_SIZE, 1));
            end else begin
              release_slice($urandom_range(65535), $urandom_range(64, 1));
            end
          end
        endcase
      end
    end
  endtask

  // Carves single slots, frees every other one so that the run table fills up, then frees the rest in random order.
  task automatic fragment_burst(input int unsigned n);
    run_t        frag[$];
    ffra_out_t   r;
    int unsigned idx;
    for (int unsigned k = 0; k < n; k++) begin
      send_command(mk_cmd(CMD_ACQUIRE, 1, $urandom_range(65535)), r);
      if (r.status == ST_OK) begin
        frag.insert(frag.size(), run_t'{start: r.granted_offset, length: r.granted_count});
      end
    end
    for (int unsigned k = 0; k < frag.size(); k += 2) begin
      release_slice(frag[k].start, frag[k].length);
    end
    for (int unsigned k = frag.size(); k > 0; k--) begin
      if ((k - 1) % 2 == 0) begin
        frag.delete(k - 1);
      end
    end
    while (frag.size() > 0) begin
      idx = $urandom_range(frag.size() - 1);
      release_slice(frag[idx].start, frag[idx].length);
      frag.delete(idx);
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_pool_ready(1'b1);

    acquire(0, 16'hFFFF);
    acquire(1, 16'h0000);
    acquire(MAX_SLICE, 16'h8000);
    acquire(POOL_SIZE, 16'h0001);
    acquire(MAX_SLICE + 1, 16'h7FFF);
    release_slice(16'hFFFF, 0);
    release_slice(0, 1);
    release_slice(1, MAX_SLICE);
    release_slice(2 * MAX_SLICE + 1, MAX_SLICE);
    release_slice(MAX_SLICE + 1, MAX_SLICE);
    held.delete();
    release_slice(16'hFFFF, 3000);
    release_slice(16'hFFFF, POOL_SIZE);
    acquire(MAX_SLICE, 16'hAAAA);
    wait_drained();
    write_pool_ready(1'b0);
    acquire(5, 16'h5555);
    acquire(POOL_SIZE, 16'h0000);
    release_slice(0, 0);
    release_slice(40000, 7);
    wait_drained();
    write_pool_ready(1'b1);
    acquire(7, 16'h1234);

    run_mix(400);
    wait_drained();
    fragment_burst(140);
    wait_drained();
    write_pool_ready(1'b0);
    run_mix(150);
    wait_drained();
    write_pool_ready(1'b1);
    run_mix(400);
    fragment_burst(140);
    wait_drained();
    calm <= 1'b1;
    run_mix(250);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
